[design/dbpo_pkg.sv]
// ----------------------------------------------------------------------------
// dbpo_pkg: shared types and helpers of the prefer-one de Bruijn generator
// Sizes of the window, position and epoch words, payload structs and the
// order, mask and last-position helpers.
// ----------------------------------------------------------------------------
package dbpo_pkg;

	localparam int MAX_ORDER   = 10;
	localparam int WIN_W       = MAX_ORDER;
	localparam int STORE_DEPTH = 1 << MAX_ORDER;
	localparam int POS_W       = MAX_ORDER + 1;
	localparam int ORDER_W     = 4;
	localparam int EPOCH_W     = 8;

	localparam logic [ORDER_W-1:0] ORDER_RESET = ORDER_W'(4);
	localparam logic [EPOCH_W-1:0] EPOCH_FIRST = EPOCH_W'(1);
	localparam logic [EPOCH_W-1:0] EPOCH_LAST  = {EPOCH_W{1'b1}};
	localparam logic [EPOCH_W-1:0] EPOCH_CLEAR = '0;

	typedef logic [WIN_W-1:0]   win_t;
	typedef logic [POS_W-1:0]   pos_t;
	typedef logic [ORDER_W-1:0] order_t;
	typedef logic [EPOCH_W-1:0] epoch_t;

	typedef struct packed {
		logic seq_bit;
		pos_t position;
		logic is_last;
		logic valid_res;
	} result_t;

	typedef struct packed {
		win_t window;
		pos_t next_position;
		logic finished;
	} seq_state_t;

	typedef struct packed {
		logic en;
		win_t addr;
	} mark_t;

	// prefetched store words, their addresses and the write of the last cycle
	typedef struct packed {
		logic   vld;
		win_t   tag0;
		win_t   tag1;
		epoch_t d0;
		epoch_t d1;
		mark_t  wr;
		epoch_t epoch;
	} lookup_t;

	typedef struct packed {
		result_t    res;
		seq_state_t nxt;
		mark_t      mark;
		win_t       rd_addr0;
		win_t       rd_addr1;
		logic       stall;
	} step_out_t;

	// saturate the order register into 1..MAX_ORDER
	function automatic order_t eff_order(input order_t ord);
		if (ord == '0) begin
			return ORDER_W'(1);
		end else if (ord > ORDER_W'(MAX_ORDER)) begin
			return ORDER_W'(MAX_ORDER);
		end
		return ord;
	endfunction

	function automatic win_t win_mask(input order_t n);
		logic [WIN_W:0] full;
		full = ((WIN_W+1)'(1) << n) - (WIN_W+1)'(1);
		return full[WIN_W-1:0];
	endfunction

	// position of the final digit: 2^n + n - 2
	function automatic pos_t last_pos(input order_t n);
		return (POS_W'(1) << n) + POS_W'(n) - POS_W'(2);
	endfunction

endpackage

[design/dbpo_item_if.sv]
// ----------------------------------------------------------------------------
// dbpo_item_if: input item channel
// Valid/ready channel that carries the restart flag of one tick.
// ----------------------------------------------------------------------------
interface dbpo_item_if;
	logic valid;
	logic ready;
	logic restart;

	modport source (output valid, output restart, input ready);
	modport sink (input valid, input restart, output ready);
endinterface

[design/dbpo_result_if.sv]
// ----------------------------------------------------------------------------
// dbpo_result_if: result item channel
// Valid/ready channel that carries one emitted digit and its status.
// ----------------------------------------------------------------------------
interface dbpo_result_if import dbpo_pkg::*; ();
	logic valid;
	logic ready;
	logic seq_bit;
	pos_t position;
	logic is_last;
	logic valid_res;

	modport source (output valid, output seq_bit, output position, output is_last,
		output valid_res, input ready);
	modport sink (input valid, input seq_bit, input position, input is_last,
		input valid_res, output ready);
endinterface

[design/dbpo_cfg_if.sv]
// ----------------------------------------------------------------------------
// dbpo_cfg_if: configuration write channel
// Valid/ready channel that carries the write data of the order register.
// ----------------------------------------------------------------------------
interface dbpo_cfg_if import dbpo_pkg::*; ();
	logic   valid;
	logic   ready;
	order_t data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

[design/dbpo_ram.sv]
// ----------------------------------------------------------------------------
// dbpo_ram: generic RAM, one write port and two registered read ports
// Reads return the word as it stood before a write in the same cycle.
// ----------------------------------------------------------------------------
module dbpo_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 1024
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr0,
	input  logic [$clog2(DEPTH)-1:0] raddr1,
	output logic [WIDTH-1:0]         rdata0,
	output logic [WIDTH-1:0]         rdata1
);

	logic [WIDTH-1:0] mem [DEPTH];

	// write and read in the same edge, old data on collision
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata0 <= mem[raddr0];
		rdata1 <= mem[raddr1];
	end

endmodule

[design/dbpo_step.sv]
// ----------------------------------------------------------------------------
// dbpo_step: digit selection of one tick
// Applies restart, emits the prefix or the prefer-one digit, marks the
// window, and picks the store addresses to read for the next tick.
// ----------------------------------------------------------------------------
module dbpo_step import dbpo_pkg::*; (
	input  seq_state_t st,
	input  logic       restart,
	input  logic       tick,
	input  order_t     n,
	input  lookup_t    lk,
	output step_out_t  so
);

	win_t   mask;
	pos_t   last;
	win_t   s_w;
	pos_t   s_pos;
	logic   s_fin;
	win_t   wm;
	win_t   cand;
	win_t   wq_m;
	win_t   cand_q;
	win_t   wa;
	win_t   wb;
	logic   hit0;
	logic   hit1;
	logic   hit_q;
	epoch_t rd;
	logic   visited;
	logic   need_mem_q;
	logic   digit;

	always_comb begin
		mask  = win_mask(n);
		last  = last_pos(n);

		// restart clears window, position and finished flag first
		s_w   = restart ? '0 : st.window;
		s_pos = restart ? '0 : st.next_position;
		s_fin = restart ? 1'b0 : st.finished;
		wm    = s_w & mask;
		cand  = ((wm << 1) | WIN_W'(1)) & mask;

		// store lookup for the candidate window; mark of this tick and of the
		// previous cycle are bypassed around the registered read
		hit0    = lk.vld && (lk.tag0 == cand);
		hit1    = lk.vld && (lk.tag1 == cand);
		rd      = hit0 ? lk.d0 : lk.d1;
		visited = ((hit0 || hit1) && (rd == lk.epoch)) ||
			(lk.wr.en && (lk.wr.addr == cand)) || (cand == wm);

		// stall check from the held state alone: a restart never needs the store
		wq_m       = st.window & mask;
		cand_q     = ((wq_m << 1) | WIN_W'(1)) & mask;
		hit_q      = lk.vld && ((lk.tag0 == cand_q) || (lk.tag1 == cand_q));
		need_mem_q = !st.finished && (st.next_position <= last) &&
			(st.next_position >= POS_W'(n));
		so.stall   = need_mem_q && !hit_q;

		digit   = 1'b0;
		so.res  = '0;
		so.mark = '0;
		so.nxt.window        = s_w;
		so.nxt.next_position = s_pos;
		so.nxt.finished      = 1'b1;

		if (!s_fin && (s_pos <= last)) begin
			if (s_pos < POS_W'(n)) begin
				digit = (s_pos == POS_W'(n) - POS_W'(1));
			end else begin
				so.mark.en   = tick;
				so.mark.addr = wm;
				digit        = !visited;
			end
			so.res.seq_bit       = digit;
			so.res.position      = s_pos;
			so.res.is_last       = (s_pos == last);
			so.res.valid_res     = 1'b1;
			so.nxt.window        = ((wm << 1) | WIN_W'(digit)) & mask;
			so.nxt.next_position = s_pos + POS_W'(1);
			so.nxt.finished      = (s_pos == last);
		end

		// prefetch both candidates of the next window, or refresh the current one
		wa = (wm << 1) & mask;
		wb = wa | WIN_W'(1);
		if (tick) begin
			so.rd_addr0 = ((wa << 1) | WIN_W'(1)) & mask;
			so.rd_addr1 = ((wb << 1) | WIN_W'(1)) & mask;
		end else begin
			so.rd_addr0 = cand_q;
			so.rd_addr1 = cand_q;
		end
	end

endmodule

[design/dbpo_skid.sv]
// ----------------------------------------------------------------------------
// dbpo_skid: result register with skid stage
// Holds up to two results so the input side never waits on the output
// ready in the same cycle.
// ----------------------------------------------------------------------------
module dbpo_skid import dbpo_pkg::*; (
	input  logic    clk,
	input  logic    arst_n,
	input  logic    push,
	input  result_t push_data,
	output logic    full,
	dbpo_result_if.source result
);

	logic    main_vld_q;
	logic    skid_vld_q;
	result_t main_q;
	result_t skid_q;
	logic    take;

	assign take = main_vld_q && result.ready;
	assign full = skid_vld_q;

	// control: move skid into main on a transfer, else park a push
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			main_vld_q <= 1'b0;
			skid_vld_q <= 1'b0;
		end else if (skid_vld_q) begin
			if (take) begin
				skid_vld_q <= 1'b0;
			end
		end else if (push) begin
			if (main_vld_q && !take) begin
				skid_vld_q <= 1'b1;
			end else begin
				main_vld_q <= 1'b1;
			end
		end else if (take) begin
			main_vld_q <= 1'b0;
		end
	end

	// payload
	always_ff @(posedge clk) begin
		if (skid_vld_q) begin
			if (take) begin
				main_q <= skid_q;
			end
		end else if (push) begin
			if (main_vld_q && !take) begin
				skid_q <= push_data;
			end else begin
				main_q <= push_data;
			end
		end
	end

	assign result.valid     = main_vld_q;
	assign result.seq_bit   = main_q.seq_bit;
	assign result.position  = main_q.position;
	assign result.is_last   = main_q.is_last;
	assign result.valid_res = main_q.valid_res;

`ifndef NO_ASSERTIONS
	// a parked result always has one ahead of it
	a_skid_behind_main: assert property (@(posedge clk) disable iff (!arst_n)
		skid_vld_q |-> main_vld_q)
		else $error("skid stage holds a result with the main register empty");
`endif

endmodule

[design/debruijn_prefer_one_generator.sv]
// ----------------------------------------------------------------------------
// debruijn_prefer_one_generator: binary de Bruijn sequence, prefer-one rule
//
//   channel  dir  handshake     payload
//   cfg      in   valid/ready   data: order (4 bits)
//   item     in   valid/ready   restart
//   result   out  valid/ready   seq_bit, position, is_last, valid_res
//
// One item per cycle while the input is not held off: each tick costs at most
// one visited-store write, and the store reads for the next window are issued
// ahead of it on both read ports. Results leave through a result register
// with a skid stage. After reset a clearing pass sweeps the whole store; the
// same pass runs after every 255th restart, when the epoch mark wraps.
// An item is held off after an order change or a clearing pass while the store
// is re-read; a full skid stage also holds the input.
// ----------------------------------------------------------------------------
module debruijn_prefer_one_generator import dbpo_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	dbpo_cfg_if.sink      cfg,
	dbpo_item_if.sink     item,
	dbpo_result_if.source result
);

	order_t     order_q;
	seq_state_t state_q;
	epoch_t     epoch_q;
	logic       clear_busy_q;
	win_t       clear_addr_q;
	logic       pf_vld_q;
	win_t       tag0_q;
	win_t       tag1_q;
	mark_t      wr_q;
	epoch_t     rdata0;
	epoch_t     rdata1;
	order_t     n;
	logic       tick;
	logic       skid_full;
	lookup_t    lk;
	step_out_t  so;
	logic       ram_we;
	win_t       ram_waddr;
	epoch_t     ram_wdata;

	// configuration register, always ready
	assign cfg.ready = 1'b1;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			order_q <= ORDER_RESET;
		end else if (cfg.valid) begin
			order_q <= cfg.data;
		end
	end

	assign n          = eff_order(order_q);
	assign item.ready = !clear_busy_q && !skid_full && !so.stall;
	assign tick       = item.valid && item.ready;

	assign lk.vld   = pf_vld_q;
	assign lk.tag0  = tag0_q;
	assign lk.tag1  = tag1_q;
	assign lk.d0    = rdata0;
	assign lk.d1    = rdata1;
	assign lk.wr    = wr_q;
	assign lk.epoch = epoch_q;

	dbpo_step u_step (
		.st      (state_q),
		.restart (item.restart),
		.tick    (tick),
		.n       (n),
		.lk      (lk),
		.so      (so)
	);

	// store write: clearing sweep or window mark
	always_comb begin
		if (clear_busy_q) begin
			ram_we    = 1'b1;
			ram_waddr = clear_addr_q;
			ram_wdata = EPOCH_CLEAR;
		end else begin
			ram_we    = so.mark.en;
			ram_waddr = so.mark.addr;
			ram_wdata = epoch_q;
		end
	end

	dbpo_ram #(
		.WIDTH (EPOCH_W),
		.DEPTH (STORE_DEPTH)
	) u_store (
		.clk    (clk),
		.we     (ram_we),
		.waddr  (ram_waddr),
		.wdata  (ram_wdata),
		.raddr0 (so.rd_addr0),
		.raddr1 (so.rd_addr1),
		.rdata0 (rdata0),
		.rdata1 (rdata1)
	);

	// sequence state, epoch and clearing sweep
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= '0;
			epoch_q      <= EPOCH_FIRST;
			clear_busy_q <= 1'b1;
			clear_addr_q <= '0;
			pf_vld_q     <= 1'b0;
			wr_q         <= '0;
		end else begin
			pf_vld_q <= !clear_busy_q;
			wr_q     <= clear_busy_q ? '0 : so.mark;
			if (clear_busy_q) begin
				clear_addr_q <= clear_addr_q + WIN_W'(1);
				if (&clear_addr_q) begin
					clear_busy_q <= 1'b0;
				end
			end
			if (tick) begin
				state_q <= so.nxt;
				if (item.restart) begin
					if (epoch_q == EPOCH_LAST) begin
						epoch_q      <= EPOCH_FIRST;
						clear_busy_q <= 1'b1;
						clear_addr_q <= '0;
					end else begin
						epoch_q <= epoch_q + EPOCH_W'(1);
					end
				end
			end
		end
	end

	// prefetch tags follow the read addresses
	always_ff @(posedge clk) begin
		tag0_q <= so.rd_addr0;
		tag1_q <= so.rd_addr1;
	end

	dbpo_skid u_skid (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (tick),
		.push_data (so.res),
		.full      (skid_full),
		.result    (result)
	);

`ifndef NO_ASSERTIONS
	// no transfer while the store is being swept
	a_no_tick_in_clear: assert property (@(posedge clk) disable iff (!arst_n)
		clear_busy_q |-> !item.ready)
		else $error("input accepted during the clearing sweep");

	// a valid digit without restart advances the position by one
	a_pos_advance: assert property (@(posedge clk) disable iff (!arst_n)
		(tick && !item.restart && so.res.valid_res) |=>
		(state_q.next_position == $past(state_q.next_position) + POS_W'(1)))
		else $error("position did not advance by one");

	// finished holds until a restart
	a_finished_holds: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q.finished && !(tick && item.restart)) |=> state_q.finished)
		else $error("finished flag dropped without restart");

	// the cleared value is never a live epoch
	a_epoch_live: assert property (@(posedge clk) disable iff (!arst_n)
		epoch_q != EPOCH_CLEAR)
		else $error("epoch mark equals the cleared value");
`endif

endmodule
